// File: hdl/tvn_pkg.sv
// Shared constants and types for the tileable value-noise block.
package tvn_pkg;
    localparam int OCTAVES   = 7;
    localparam int CORNERS   = 4;
    localparam int HASHES    = OCTAVES * CORNERS;
    localparam int COORD_W   = 12;
    localparam int FRAC_W    = 7;
    localparam int CFG_W     = 4;
    localparam int NOISE_W   = 8;
    localparam int MIN_WL    = 7;
    localparam int CFG_RESET = 10;

    localparam logic [31:0] HASH_ROW   = 32'd57;
    localparam logic [31:0] HASH_MUL   = 32'd15731;
    localparam logic [31:0] HASH_ADD1  = 32'd789221;
    localparam logic [31:0] HASH_ADD2  = 32'd1376312589;
    localparam logic [23:0] HASH_DIV   = 24'h7fffff;

    typedef logic [31:0]        t_word;
    typedef logic [30:0]        t_hash_t;
    typedef logic [7:0]         t_byte;
    typedef logic [15:0]        t_edge_sum;
    typedef logic [FRAC_W-1:0]  t_frac;
endpackage

// File: hdl/tvn_if.sv
// Valid/ready channels: pixel coordinates in, noise samples out.
interface tvn_in_if;
    logic                         valid;
    logic                         ready;
    logic [tvn_pkg::COORD_W-1:0]  x_coord;
    logic [tvn_pkg::COORD_W-1:0]  y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface tvn_out_if;
    logic                         valid;
    logic                         ready;
    logic [tvn_pkg::NOISE_W-1:0]  noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// File: hdl/tileable_value_noise.sv
// Top level: eight-stage pipelined tileable seven-octave value-noise generator.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------
//  i_pix     | in  | valid / ready      | x_coord[11:0], y_coord[11:0]
//  o_noise   | out | valid / ready      | noise_value[7:0]
//  cfg       | in  | i_cfg_we           | i_cfg_wdata[3:0] (width_log2)
//
// One item per cycle sustained while o_noise.ready stays high. The accepting
// edge loads stage 1; o_noise.valid is driven by stage 8 (eight register
// stages). The depth is set by the hash: two chained 32x32 multiplies and
// one 32x14 multiply, each registered, then a reciprocal-free divide.
// Reset (synchronous, active low) empties the pipeline and sets width_log2
// to 10. Each stage holds its item while the next is full and stalled, so
// bubbles collapse and i_pix.ready stays high until the whole pipe is full.
module tileable_value_noise #(
    parameter int MAX_WIDTH_LOG2 = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tvn_pkg::CFG_W-1:0]     i_cfg_wdata,
    tvn_in_if.sink                        i_pix,
    tvn_out_if.source                     o_noise
);
    localparam int NS   = 8;                        // pipeline stages
    localparam int WL_W = $clog2(MAX_WIDTH_LOG2 + 1);
    localparam int H    = tvn_pkg::HASHES;
    localparam int O    = tvn_pkg::OCTAVES;

    logic [tvn_pkg::CFG_W-1:0] r_cfg;
    logic [WL_W-1:0]           wl;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    // per-hash pipeline payload
    tvn_pkg::t_word   r_n1  [H];
    tvn_pkg::t_word   r_n2  [H];
    tvn_pkg::t_word   r_n3  [H];
    tvn_pkg::t_word   r_sq2 [H];
    tvn_pkg::t_word   r_a3  [H];
    tvn_pkg::t_hash_t r_t4  [H];
    tvn_pkg::t_byte   r_h5  [H];
    tvn_pkg::t_word   n_n1  [H];
    tvn_pkg::t_word   n_sq2 [H];
    tvn_pkg::t_word   n_a3  [H];
    tvn_pkg::t_hash_t n_t4  [H];
    tvn_pkg::t_byte   n_h5  [H];

    // fractional coordinates ride along until interpolation
    tvn_pkg::t_frac   r_fx [1:6];
    tvn_pkg::t_frac   r_fy [1:5];

    tvn_pkg::t_edge_sum r_l6 [O];
    tvn_pkg::t_edge_sum r_r6 [O];
    tvn_pkg::t_edge_sum n_l6 [O];
    tvn_pkg::t_edge_sum n_r6 [O];
    tvn_pkg::t_byte     r_o7 [O];
    tvn_pkg::t_byte     n_o7 [O];
    tvn_pkg::t_byte     r_sum;
    tvn_pkg::t_byte     n_sum;

    // stage 1 temporaries
    logic [31:0] mask;
    logic [31:0] ci;
    logic [31:0] cj;
    logic [31:0] nn;
    // stage 5 temporaries
    logic [7:0]  q0;
    logic [23:0] rem;
    // stage 6/7 temporaries
    logic [7:0]  stp;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [23:0] acc;

    // width_log2 clamped to the supported range
    always_comb begin
        if (32'(r_cfg) < 32'(tvn_pkg::MIN_WL)) begin
            wl = WL_W'(tvn_pkg::MIN_WL);
        end else if (32'(r_cfg) > 32'(MAX_WIDTH_LOG2)) begin
            wl = WL_W'(MAX_WIDTH_LOG2);
        end else begin
            wl = WL_W'(r_cfg);
        end
    end

    // a stage moves when empty or when the one after it moves
    always_comb begin
        en[NS+1] = o_noise.ready;
        for (int s = NS; s >= 1; s--) begin
            en[s] = ~r_v[s] | en[s+1];
        end
    end

    assign i_pix.ready       = en[1];
    assign o_noise.valid     = r_v[NS];
    assign o_noise.noise_value = r_sum;

    // stage 1: wrapped lattice corners, n = i + 57j, n ^= n << 13
    always_comb begin
        mask = '0;
        ci   = '0;
        cj   = '0;
        nn   = '0;
        for (int o = 0; o < O; o++) begin
            mask = ((32'd1 << wl) >> (o + 1)) - 32'd1;
            for (int c = 0; c < tvn_pkg::CORNERS; c++) begin
                ci = ((32'(i_pix.x_coord) >> (o + 1)) + 32'(c % 2)) & mask;
                cj = ((32'(i_pix.y_coord) >> (o + 1)) + 32'(c / 2)) & mask;
                nn = ci + cj * tvn_pkg::HASH_ROW;
                n_n1[o*4+c] = (nn << 13) ^ nn;
            end
        end
    end

    // stages 2-5: hash polynomial and divide by 2^23-1
    always_comb begin
        q0  = '0;
        rem = '0;
        for (int h = 0; h < H; h++) begin
            n_sq2[h] = r_n1[h] * r_n1[h];
            n_a3[h]  = r_sq2[h] * tvn_pkg::HASH_MUL + tvn_pkg::HASH_ADD1;
            n_t4[h]  = 31'(r_n3[h] * r_a3[h] + tvn_pkg::HASH_ADD2);
            // t = q0*2^23 + low = q0*(2^23-1) + (low + q0); remainder < 2*divisor
            q0  = r_t4[h][30:23];
            rem = {1'b0, r_t4[h][22:0]} + 24'(q0);
            n_h5[h] = q0 + ((rem >= tvn_pkg::HASH_DIV) ? 8'd1 : 8'd0);
        end
    end

    // stages 6-8: bilinear blend, octave scaling, octave sum
    always_comb begin
        stp   = '0;
        fx    = '0;
        fy    = '0;
        acc   = '0;
        n_sum = '0;
        for (int o = 0; o < O; o++) begin
            stp = 8'd1 << (o + 1);
            fy  = {1'b0, r_fy[5]} & (stp - 8'd1);
            n_l6[o] = 16'(fy) * 16'(r_h5[o*4+2]) + 16'(stp - fy) * 16'(r_h5[o*4+0]);
            n_r6[o] = 16'(fy) * 16'(r_h5[o*4+3]) + 16'(stp - fy) * 16'(r_h5[o*4+1]);
            fx  = {1'b0, r_fx[6]} & (stp - 8'd1);
            acc = 24'(r_r6[o]) * 24'(fx) + 24'(r_l6[o]) * 24'(stp - fx);
            n_o7[o] = 8'(acc >> (2 * (o + 1))) >> (7 - o);
            n_sum   = n_sum + r_o7[o];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tvn_pkg::CFG_W'(tvn_pkg::CFG_RESET);
            r_v   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (en[1]) begin
                r_v[1] <= i_pix.valid;
            end
            for (int s = 2; s <= NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_n1    <= n_n1;
            r_fx[1] <= i_pix.x_coord[tvn_pkg::FRAC_W-1:0];
            r_fy[1] <= i_pix.y_coord[tvn_pkg::FRAC_W-1:0];
        end
        if (en[2]) begin
            r_sq2   <= n_sq2;
            r_n2    <= r_n1;
            r_fx[2] <= r_fx[1];
            r_fy[2] <= r_fy[1];
        end
        if (en[3]) begin
            r_a3    <= n_a3;
            r_n3    <= r_n2;
            r_fx[3] <= r_fx[2];
            r_fy[3] <= r_fy[2];
        end
        if (en[4]) begin
            r_t4    <= n_t4;
            r_fx[4] <= r_fx[3];
            r_fy[4] <= r_fy[3];
        end
        if (en[5]) begin
            r_h5    <= n_h5;
            r_fx[5] <= r_fx[4];
            r_fy[5] <= r_fy[4];
        end
        if (en[6]) begin
            r_l6    <= n_l6;
            r_r6    <= n_r6;
            r_fx[6] <= r_fx[5];
        end
        if (en[7]) begin
            r_o7 <= n_o7;
        end
        if (en[8]) begin
            r_sum <= n_sum;
        end
    end
endmodule

// File: hdl/tvn_checker.sv
// Port-level checks for the noise generator, bound to the top level.
module tvn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_noise
);
    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // input only backs up when the output is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output stall");

    // stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_noise)))
        else $error("stalled output changed");

    // octave sum never exceeds 247
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_noise <= 8'd247))
        else $error("noise sample out of range");
endmodule

bind tileable_value_noise tvn_checker u_tvn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_noise.valid),
    .i_out_ready (o_noise.ready),
    .i_noise     (o_noise.noise_value)
);
